// ===== rtl/string_to_integer_parser_defines.svh =====
// ----------------------------------------------------------------------------
// string_to_integer_parser assertion macros
// concurrent check helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_DEFINES_SVH
`define STRING_TO_INTEGER_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define STIP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("string_to_integer_parser check failed");

// next-cycle implication
`define STIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("string_to_integer_parser check failed");

`else

`define STIP_ASSERT_IMPLY(label, ante, cons)
`define STIP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/stip_pkg.sv =====
// ----------------------------------------------------------------------------
// stip_pkg
// shared types, character codes and helpers of the string to integer parser
// ----------------------------------------------------------------------------
package stip_pkg;

	localparam int unsigned CNT_W     = 16;
	localparam logic [CNT_W-1:0] MAX_COUNT = 16'hFFFF;
	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned BASE_W    = 6;
	localparam int unsigned CHAR_W    = 8;

	localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
	localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
	localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [BASE_W-1:0] ALPHA_OFFSET = 6'd10;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGNED,
		PH_ZERO,
		PH_HEXPRE,
		PH_DIGITS
	} phase_t;

	// one finished parse, handed from the core to the output register
	typedef struct packed {
		logic                    fire;
		logic [VALUE_W-1:0]      value;
		logic [CNT_W-1:0]        consumed;
	} stip_result_t;

	// digit value of an alphanumeric character, ok low for anything else
	typedef struct packed {
		logic              ok;
		logic [BASE_W-1:0] val;
	} digit_t;

	function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
		digit_t d;
		d.ok  = 1'b0;
		d.val = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d.ok  = 1'b1;
			d.val = BASE_W'(c - CH_ZERO);
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d.ok  = 1'b1;
			d.val = BASE_W'(c - CH_LO_A) + ALPHA_OFFSET;
		end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d.ok  = 1'b1;
			d.val = BASE_W'(c - CH_UP_A) + ALPHA_OFFSET;
		end
		return d;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
		return (n >= MAX_COUNT) ? MAX_COUNT : n + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/stip_core.sv =====
// ----------------------------------------------------------------------------
// stip_core
// per-string parse state and the combinational character step
// ----------------------------------------------------------------------------
module stip_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [stip_pkg::CHAR_W-1:0]   ch,
	input  logic                          start_req,
	input  logic [stip_pkg::BASE_W-1:0]   number_base,
	output stip_pkg::stip_result_t        res
);
	import stip_pkg::*;

	phase_t               phase_q, phase_d;
	logic                 neg_q, neg_d;
	logic [BASE_W-1:0]    base_q, base_d;
	logic [VALUE_W-1:0]   acc_q, acc_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [CNT_W-1:0]     end_q, end_d;
	logic                 fire;

	// state as seen by this character: a start drops the string in progress
	phase_t               ph_e;
	logic                 neg_e;
	logic [BASE_W-1:0]    base_e;
	logic [VALUE_W-1:0]   acc_e;
	logic [CNT_W-1:0]     cnt_e;
	logic [CNT_W-1:0]     end_e;
	digit_t               dig;

	assign ph_e   = start_req ? PH_LEAD     : phase_q;
	assign neg_e  = start_req ? 1'b0        : neg_q;
	assign base_e = start_req ? number_base : base_q;
	assign acc_e  = start_req ? '0          : acc_q;
	assign cnt_e  = start_req ? '0          : cnt_q;
	assign end_e  = start_req ? '0          : end_q;
	assign dig    = digit_of(ch);

	// next state
	always_comb begin : ns_comb
		logic done;
		done    = 1'b0;
		phase_d = ph_e;
		neg_d   = neg_e;
		base_d  = base_e;
		acc_d   = acc_e;
		cnt_d   = cnt_e;
		end_d   = end_e;
		fire    = 1'b0;
		if (ph_e == PH_IDLE) begin
			done = 1'b1;
		end
		if (!done && phase_d == PH_LEAD) begin
			if (ch == CH_SPACE) begin
				cnt_d = sat_inc(cnt_d);
				done  = 1'b1;
			end else begin
				phase_d = PH_SIGNED;
				if (ch == CH_MINUS || ch == CH_PLUS) begin
					neg_d = (ch == CH_MINUS);
					cnt_d = sat_inc(cnt_d);
					done  = 1'b1;
				end
			end
		end
		if (!done && phase_d == PH_SIGNED) begin
			if ((base_d == BASE_AUTO || base_d == BASE_HEX) && ch == CH_ZERO) begin
				// leading zero counts as a digit; accumulator is still zero
				end_d   = sat_inc(cnt_d);
				cnt_d   = sat_inc(cnt_d);
				phase_d = PH_ZERO;
				done    = 1'b1;
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_DEC;
				end
				phase_d = PH_DIGITS;
			end
		end else if (!done && phase_d == PH_ZERO) begin
			if (ch == CH_LO_X || ch == CH_UP_X) begin
				base_d  = BASE_HEX;
				cnt_d   = sat_inc(cnt_d);
				phase_d = PH_HEXPRE;
				done    = 1'b1;
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_OCT;
				end
				phase_d = PH_DIGITS;
			end
		end
		if (!done) begin
			if (dig.ok && base_d >= BASE_MIN && base_d <= BASE_MAX && dig.val < base_d) begin
				acc_d   = acc_d * VALUE_W'(base_d) + VALUE_W'(dig.val);
				end_d   = sat_inc(cnt_d);
				cnt_d   = sat_inc(cnt_d);
				phase_d = PH_DIGITS;
			end else begin
				fire    = 1'b1;
				phase_d = PH_IDLE;
			end
		end
	end

	// result; a stop never changes sign, accumulator or end count in its cycle
	always_comb begin
		res.fire     = fire;
		res.value    = '0;
		res.consumed = '0;
		if (end_e != '0) begin
			res.value    = neg_e ? (VALUE_W'(0) - acc_e) : acc_e;
			res.consumed = end_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			end_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			base_q  <= base_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			end_q   <= end_d;
		end
	end

endmodule

// ===== rtl/string_to_integer_parser.sv =====
// ----------------------------------------------------------------------------
// string_to_integer_parser
// streaming strtol-style parser, one character per request
// ----------------------------------------------------------------------------
// usage: send characters on the slave stream, with s_tuser high on the first
// character of each string; leading spaces are skipped, one sign is taken,
// and digits in the base from number_base (0 detects 0x / 0 / decimal from
// the prefix) are accumulated modulo 2^64; the first character that is not a
// digit of the base, NUL included, ends the string and produces one result
// request with the signed value and the count of characters up to the last
// digit (both zero when no digit was seen); input after the end is dropped
// until the next start, and a start in mid-string discards the old string
// without a result. a character register feeds a single step of compare
// logic plus one 64 by 6 multiply-add, and a result register toward the
// master side, so one character is accepted every cycle while the result
// side keeps up. number_base is sampled on the start character and may only
// be written while the parser is idle.
// ----------------------------------------------------------------------------
`include "string_to_integer_parser_defines.svh"

module string_to_integer_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [stip_pkg::BASE_W-1:0]   cfg_wdata,    // number_base
	// character stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,      // [7:0] ch
	input  logic                          s_tuser,      // [0] start_req
	// result stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [79:0]                   m_tdata       // [63:0] value, [79:64] consumed
);
	import stip_pkg::*;

	// base register, latched into the core on each start
	logic [BASE_W-1:0]    number_base_q;

	// character stage
	logic                 valid_s1;
	logic [CHAR_W-1:0]    ch_s1;
	logic                 start_s1;

	// result stage
	logic                 out_valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic [CNT_W-1:0]     consumed_q;

	logic                 advance;
	stip_result_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= BASE_RESET;
		end else if (cfg_we) begin
			number_base_q <= cfg_wdata;
		end
	end

	// the staged character steps the core as soon as the result slot is free
	// or being emptied in the same cycle
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1    <= s_tdata[CHAR_W-1:0];
			start_s1 <= s_tuser;
		end
	end

	stip_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.ch          (ch_s1),
		.start_req   (start_s1),
		.number_base (number_base_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.fire) begin
			value_q    <= res.value;
			consumed_q <= res.consumed;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {consumed_q, value_q};

	// an empty result slot never blocks the character side
	`STIP_ASSERT_IMPLY(a_ready_when_empty, !m_tvalid, s_tready)
	// the only cause of input backpressure is a stalled result
	`STIP_ASSERT_IMPLY(a_stall_cause, valid_s1 && !s_tready, m_tvalid && !m_tready)
	// an accepted character is staged in the next cycle
	`STIP_ASSERT_NEXT(a_accept_staged, s_tvalid && s_tready, valid_s1)
	// no digits means a zero value
	`STIP_ASSERT_IMPLY(a_empty_zero, m_tvalid && m_tdata[79:64] == 16'h0000,
		m_tdata[63:0] == 64'h0)

endmodule
